[hw/rtl/lsprc_pkg.sv]
// Shared types, constants and a helper function of the Latin square pair repeat counter.
`timescale 1ns / 1ps

package lsprc_pkg;

	localparam int SYM_W         = 5;
	localparam int ORDER_W       = 5;
	localparam int COUNT_W       = 8;
	localparam int NUM_MAPS      = 5;
	localparam int MAX_ORDER_DEF = 16;

	localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(16);

	// Configuration port: byte addresses, one 32-bit register per word.
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_SQUARE_ORDER = 1'b0;

	// Bitmap and counter slots.
	localparam int MAP_ORTHO       = 0;
	localparam int MAP_FIRST_ROWS  = 1;
	localparam int MAP_SECOND_ROWS = 2;
	localparam int MAP_FIRST_DIAG  = 3;
	localparam int MAP_SECOND_DIAG = 4;

	typedef logic [SYM_W-1:0]   sym_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef struct packed {
		sym_t cell_first;
		sym_t cell_second;
	} cell_word_t;

	typedef struct packed {
		count_t orthogonal_repeats;
		count_t first_row_pair_repeats;
		count_t second_row_pair_repeats;
		count_t first_to_second_diag_repeats;
		count_t second_to_first_diag_repeats;
	} result_word_t;

	// One symbol pair to test and set in a bitmap.
	typedef struct packed {
		logic active;
		sym_t left;
		sym_t right;
	} pair_req_t;

	// Pipeline control shared by all bitmaps.
	typedef struct packed {
		logic advance;
		logic commit;
		logic wipe;
	} map_ctl_t;

	function automatic count_t sat_inc(input count_t count, input logic hit);
		count_t result;
		result = count;
		if (hit && (count != '1)) begin
			result = count + count_t'(1);
		end
		return result;
	endfunction

endpackage

[hw/rtl/lsprc_bitmap.sv]
// One seen-pair bitmap: row memory with row valid bits and read-modify-write forwarding.
`timescale 1ns / 1ps

module lsprc_bitmap #(
	parameter int MAX_ORDER = lsprc_pkg::MAX_ORDER_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lsprc_pkg::map_ctl_t  ctl,
	input  lsprc_pkg::pair_req_t req,
	output logic                 hit
);

	import lsprc_pkg::*;

	localparam int RW = $clog2(MAX_ORDER);

	// Row r holds the seen bits of all pairs whose left symbol is r.
	logic [MAX_ORDER-1:0] mem [MAX_ORDER];

	logic [MAX_ORDER-1:0] rd_word_s1;
	logic [MAX_ORDER-1:0] row_word;
	logic [MAX_ORDER-1:0] set_word;
	logic [MAX_ORDER-1:0] fwd_word_q;
	logic [MAX_ORDER-1:0] row_valid_q;
	logic [RW-1:0]        req_row;
	logic [RW-1:0]        req_col;
	logic [RW-1:0]        row_s1;
	logic [RW-1:0]        col_s1;
	logic [RW-1:0]        fwd_row_q;
	logic                 active_s1;
	logic                 fwd_en_q;
	logic                 wr_en;

	assign req_row = RW'(req.left);
	assign req_col = RW'(req.right);

	// The row written at the edge this item was read is newer than the memory data.
	always_comb begin
		if (fwd_en_q && (fwd_row_q == row_s1)) begin
			row_word = fwd_word_q;
		end else if (row_valid_q[row_s1]) begin
			row_word = rd_word_s1;
		end else begin
			row_word = '0;
		end
	end

	assign hit      = active_s1 & row_word[col_s1];
	assign set_word = row_word | ({{(MAX_ORDER-1){1'b0}}, 1'b1} << col_s1);
	assign wr_en    = ctl.commit & active_s1 & ~row_word[col_s1];

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			rd_word_s1 <= mem[req_row];
		end
		if (wr_en) begin
			mem[row_s1] <= set_word;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			row_s1 <= req_row;
			col_s1 <= req_col;
		end
		if (wr_en) begin
			fwd_word_q <= set_word;
			fwd_row_q  <= row_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_s1   <= 1'b0;
			row_valid_q <= '0;
			fwd_en_q    <= 1'b0;
		end else begin
			if (ctl.advance) begin
				active_s1 <= req.active;
			end
			if (ctl.wipe) begin
				row_valid_q <= '0;
				fwd_en_q    <= 1'b0;
			end else begin
				if (wr_en) begin
					row_valid_q[row_s1] <= 1'b1;
				end
				if (ctl.advance) begin
					fwd_en_q <= wr_en;
				end
			end
		end
	end

endmodule

[hw/rtl/lsprc_tracker.sv]
// Cell position tracking and formation of the five symbol pairs of each word.
`timescale 1ns / 1ps

module lsprc_tracker #(
	parameter int MAX_ORDER = lsprc_pkg::MAX_ORDER_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        accept,
	input  logic                                        restart,
	input  lsprc_pkg::cell_word_t                       cell_data,
	input  logic [lsprc_pkg::ORDER_W-1:0]               square_order,
	output lsprc_pkg::pair_req_t [lsprc_pkg::NUM_MAPS-1:0] reqs,
	output logic                                        last
);

	import lsprc_pkg::*;

	localparam int POS_W = $clog2(MAX_ORDER);
	localparam int CMP_W = (POS_W + 1 > ORDER_W) ? POS_W + 1 : ORDER_W;

	logic [ORDER_W-1:0] order_n;
	logic [POS_W-1:0]   col_q;
	logic [POS_W-1:0]   row_q;
	sym_t               prev_first_q;
	sym_t               prev_second_q;
	sym_t               a;
	sym_t               b;
	logic               a_ok;
	logic               b_ok;
	logic               pf_ok;
	logic               ps_ok;
	logic               col_nz;
	logic               col_end;
	logic               row_end;

	// Order zero acts as one; orders above the bitmap size are clamped.
	always_comb begin
		if (square_order == '0) begin
			order_n = ORDER_W'(1);
		end else if (int'(square_order) > MAX_ORDER) begin
			order_n = ORDER_W'(MAX_ORDER);
		end else begin
			order_n = square_order;
		end
	end

	assign a       = cell_data.cell_first;
	assign b       = cell_data.cell_second;
	assign a_ok    = (a < order_n);
	assign b_ok    = (b < order_n);
	assign pf_ok   = (prev_first_q < order_n);
	assign ps_ok   = (prev_second_q < order_n);
	assign col_nz  = (col_q != '0);
	assign col_end = (CMP_W'(col_q) + CMP_W'(1)) >= CMP_W'(order_n);
	assign row_end = (CMP_W'(row_q) + CMP_W'(1)) >= CMP_W'(order_n);
	assign last    = col_end & row_end;

	always_comb begin
		reqs[MAP_ORTHO]       = '{active: accept & a_ok & b_ok, left: a, right: b};
		reqs[MAP_FIRST_ROWS]  = '{active: accept & col_nz & pf_ok & a_ok,
			left: prev_first_q, right: a};
		reqs[MAP_SECOND_ROWS] = '{active: accept & col_nz & ps_ok & b_ok,
			left: prev_second_q, right: b};
		reqs[MAP_FIRST_DIAG]  = '{active: accept & col_nz & pf_ok & b_ok,
			left: prev_first_q, right: b};
		reqs[MAP_SECOND_DIAG] = '{active: accept & col_nz & ps_ok & a_ok,
			left: prev_second_q, right: a};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q         <= '0;
			row_q         <= '0;
			prev_first_q  <= '0;
			prev_second_q <= '0;
		end else if (restart) begin
			col_q         <= '0;
			row_q         <= '0;
			prev_first_q  <= '0;
			prev_second_q <= '0;
		end else if (accept) begin
			if (last) begin
				col_q         <= '0;
				row_q         <= '0;
				prev_first_q  <= '0;
				prev_second_q <= '0;
			end else begin
				prev_first_q  <= a;
				prev_second_q <= b;
				if (col_end) begin
					col_q <= '0;
					row_q <= row_q + POS_W'(1);
				end else begin
					col_q <= col_q + POS_W'(1);
				end
			end
		end
	end

endmodule

[hw/rtl/latin_square_pair_repeat_counter_core.sv]
// Top level of the Latin square pair repeat counter: pipeline control, counters, registers.
`timescale 1ns / 1ps

// Usage: two grids of the same order are streamed cell by cell in row-major order, one
// cell word (first symbol, second symbol) per handshake on the cell channel. A symbol at
// or above the order is an empty cell and takes part in no pair. The order is set through
// the APB register at address 0 and may only be written while the block is idle; each
// write restarts the grid at cell (0, 0) and clears every seen bit and count.
// The block takes one cell word per clock cycle. Each word is read from the five row
// memories in the cycle it is accepted and tested, counted and written back in the
// second stage; a write to the row just read is forwarded, so no stall is needed between
// words. After the last cell of a grid leaves the second stage, the result word with the
// five saturating counts is loaded into the output register on the result channel, and
// all accumulation state is cleared at once through per-row valid bits, so the next grid
// starts at once. The result sits in an output register: while it waits, further cells of
// the next grid are still accepted, and only the last cell of that grid is held until the
// receiver takes the pending result. Reset clears all state and sets the order to 16;
// there is no clearing pass.

module latin_square_pair_repeat_counter_core #(
	parameter int MAX_ORDER = lsprc_pkg::MAX_ORDER_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lsprc_pkg::APB_AW-1:0]  paddr,
	input  logic [lsprc_pkg::APB_DW-1:0]  pwdata,
	output logic [lsprc_pkg::APB_DW-1:0]  prdata,
	output logic                          pready,
	input  logic                          cell_valid,
	output logic                          cell_ready,
	input  lsprc_pkg::cell_word_t         cell_data,
	output logic                          result_valid,
	input  logic                          result_ready,
	output lsprc_pkg::result_word_t       result
);

	import lsprc_pkg::*;

	logic [ORDER_W-1:0]                  square_order_q;
	logic                                reg_idx;
	logic                                cfg_write;
	logic                                accept;
	logic                                advance;
	logic                                last;
	logic                                s1_valid_q;
	logic                                s1_last_q;
	logic                                retire;
	logic                                load_result;
	logic                                result_valid_q;
	result_word_t                        result_q;
	result_word_t                        result_d;
	pair_req_t [NUM_MAPS-1:0]            reqs;
	logic [NUM_MAPS-1:0]                 map_hit;
	map_ctl_t                            map_ctl;
	logic [NUM_MAPS-1:0][COUNT_W-1:0]    count_q;
	logic [NUM_MAPS-1:0][COUNT_W-1:0]    count_next;

	// The register index is the word address.
	assign reg_idx   = paddr[2];
	assign cfg_write = psel & penable & pwrite & (reg_idx == REG_SQUARE_ORDER);
	assign pready    = 1'b1;

	always_comb begin
		if (reg_idx == REG_SQUARE_ORDER) begin
			prdata = {{(APB_DW-ORDER_W){1'b0}}, square_order_q};
		end else begin
			prdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			square_order_q <= ORDER_RESET;
		end else if (cfg_write) begin
			square_order_q <= pwdata[ORDER_W-1:0];
		end
	end

	// The second stage only holds when it carries the last cell of a grid and the
	// previous result is still waiting in the output register.
	assign advance     = ~s1_valid_q | ~s1_last_q | ~result_valid_q | result_ready;
	assign cell_ready  = advance;
	assign accept      = cell_valid & advance;
	assign retire      = advance & s1_valid_q;
	assign load_result = retire & s1_last_q;

	assign map_ctl = '{advance: advance, commit: retire & ~s1_last_q,
		wipe: load_result | cfg_write};

	lsprc_tracker #(
		.MAX_ORDER (MAX_ORDER)
	) u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.restart      (cfg_write),
		.cell_data    (cell_data),
		.square_order (square_order_q),
		.reqs         (reqs),
		.last         (last)
	);

	for (genvar m = 0; m < NUM_MAPS; m++) begin : g_map
		lsprc_bitmap #(
			.MAX_ORDER (MAX_ORDER)
		) u_bitmap (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (map_ctl),
			.req    (reqs[m]),
			.hit    (map_hit[m])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s1_last_q  <= 1'b0;
		end else if (advance) begin
			s1_valid_q <= accept;
			s1_last_q  <= accept & last;
		end
	end

	// Each count includes the hit of the cell now in the second stage.
	always_comb begin
		for (int m = 0; m < NUM_MAPS; m++) begin
			count_next[m] = sat_inc(count_q[m], map_hit[m]);
		end
	end

	always_comb begin
		result_d.orthogonal_repeats           = count_next[MAP_ORTHO];
		result_d.first_row_pair_repeats       = count_next[MAP_FIRST_ROWS];
		result_d.second_row_pair_repeats      = count_next[MAP_SECOND_ROWS];
		result_d.first_to_second_diag_repeats = count_next[MAP_FIRST_DIAG];
		result_d.second_to_first_diag_repeats = count_next[MAP_SECOND_DIAG];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_write || load_result) begin
			count_q <= '0;
		end else if (retire) begin
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_result) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_result) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef ASSERT_OFF
	// The cell channel only stalls behind a finished grid whose result cannot leave.
	a_stall_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !cell_ready) |-> (s1_last_q && result_valid_q && !result_ready))
		else $error("cell channel stalled without a pending result");

	// Once a grid's result is loaded into the output register, every count starts again from zero.
	a_counts_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		load_result |=> (count_q == '0))
		else $error("counts not cleared after the last cell");

	// No bitmap reports a repeat while the second stage is empty.
	a_no_hit_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> (map_hit == '0))
		else $error("bitmap hit without a cell in flight");
`endif

endmodule
